// File: hw/rtl/spe_pkg.sv
package spe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ExpW  = 5;
  // Width of the exponent bit pointer; at least one bit.
  localparam int unsigned BitW  = (ExpW > 1) ? $clog2(ExpW) : 1;

  typedef logic [DataW-1:0] data_t;
  typedef logic [ExpW-1:0]  exp_t;
  typedef logic [BitW-1:0]  bit_idx_t;

  typedef struct packed {
    logic  en;
    data_t a;
    data_t b;
  } mul_req_t;

endpackage

// File: hw/rtl/sparse_polynomial_evaluator.sv
// Sparse polynomial evaluator.
// Configuration: cfg_we_i/cfg_wdata_i write the evaluation point. Write it
// only while no term is in progress; each term latches the point on entry.
// Input channel: one request per term (coefficient, exponent, last flag),
// taken when in_valid_i is high and in_stall_o is low.
// Output channel: one request per polynomial, carrying the wrapped value,
// presented on out_valid_o/value_o and held until out_stall_i is low.
// Operation: a term is taken, then the point is raised to the
// exponent by square-and-multiply on one shared registered multiplier:
// one squaring per exponent bit, one more multiply per set bit, then the
// coefficient multiply and the accumulate step. The value of a polynomial
// appears in the cycle after its last term finishes accumulating.
// The output register holds a finished value while the next terms run; only
// a second last term finding the output still stalled waits for it.
// Reset clears the point and the running sum to zero and empties the output.
module sparse_polynomial_evaluator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic signed [spe_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [spe_pkg::DataW-1:0]   term_coeff_i,
  input  logic        [spe_pkg::ExpW-1:0]    term_exp_i,
  input  logic                               last_term_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [spe_pkg::DataW-1:0]   value_o
);
  import spe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_MB   = 3'd2;
  localparam logic [2:0] ST_CO   = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;

  logic [2:0] state_q, state_d;
  data_t      point_q;
  data_t      sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  data_t      out_q;
  data_t      base_q, coeff_q;
  exp_t       exp_q;
  logic       last_q;
  bit_idx_t   bit_q, bit_d;
  logic       first_q, first_d;

  mul_req_t   mul_req;
  data_t      prod;
  data_t      acc_val;
  data_t      sum_next;
  logic       in_accept;
  logic       out_free;
  logic       emit;

  spe_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // Before the first squaring the power accumulator is one.
  assign acc_val    = first_q ? data_t'(1) : prod;
  assign sum_next   = sum_q + prod;
  assign emit       = (state_q == ST_ACC) && last_q && out_free;

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = prod;
    mul_req.b  = prod;
    case (state_q)
      ST_SQ: begin
        mul_req.en = 1'b1;
        mul_req.a  = acc_val;
        mul_req.b  = acc_val;
      end
      ST_MB: begin
        mul_req.en = 1'b1;
        mul_req.b  = base_q;
      end
      ST_CO: begin
        mul_req.en = 1'b1;
        mul_req.b  = coeff_q;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    first_d     = first_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SQ;
          bit_d   = bit_idx_t'(ExpW - 1);
          first_d = 1'b1;
        end
      end
      ST_SQ: begin
        first_d = 1'b0;
        if (exp_q[bit_q]) begin
          state_d = ST_MB;
        end else if (bit_q == '0) begin
          state_d = ST_CO;
        end else begin
          bit_d = bit_q - bit_idx_t'(1);
        end
      end
      ST_MB: begin
        if (bit_q == '0) begin
          state_d = ST_CO;
        end else begin
          state_d = ST_SQ;
          bit_d   = bit_q - bit_idx_t'(1);
        end
      end
      ST_CO: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!last_q) begin
          sum_d   = sum_next;
          state_d = ST_IDLE;
        end else if (out_free) begin
          sum_d       = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      point_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      first_q     <= first_d;
      if (cfg_we_i) begin
        point_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_q  <= point_q;
      coeff_q <= term_coeff_i;
      exp_q   <= term_exp_i;
      last_q  <= last_term_i;
    end
    if (emit) begin
      out_q <= sum_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_SQ) && first_q)
    else $error("accepted term did not start the power sequence");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && (sum_q == '0) && (state_q == ST_IDLE))
    else $error("last term did not produce a value and clear the sum");

  a_sq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |=> (state_q == ST_SQ) || (state_q == ST_MB) ||
                           (state_q == ST_CO))
    else $error("squaring step left the power sequence");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled result was lost or overwritten");

endmodule

// File: hw/rtl/spe_mul.sv
module spe_mul (
  input  logic              clk_i,
  input  spe_pkg::mul_req_t req_i,
  output spe_pkg::data_t    prod_o
);
  import spe_pkg::*;

  data_t              prod_d;
  data_t              prod_q;

  // Only the low word is kept, so the product wraps modulo 2^DataW.
  assign prod_d = req_i.a * req_i.b;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: dv/testbench.sv
module testbench;
  import spe_pkg::*;

  localparam data_t DataMax = 32'h7fff_ffff;
  localparam data_t DataMin = 32'h8000_0000;
  localparam data_t AllOnes = 32'hffff_ffff;
  localparam int RandomTerms = 2000;
  localparam int QuietTail = 300;       // last terms sent with no idling at all
  localparam int SettleCycles = 24;     // longer than one term occupies the block
  localparam int HoldCycles = 200;
  localparam int WatchdogLimit = 2000;
  localparam int DirectedRows = 24;

  typedef enum logic {
    ROW_TERM,
    ROW_POINT
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    data_t     data;    // coefficient of a term, or the new point
    exp_t      e;
    logic      last;
    logic      fixed;   // answer below is typed in rather than predicted
    data_t     answer;
  } row_t;

  typedef struct packed {
    logic  fixed;
    data_t answer;
  } known_answer_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic signed [DataW-1:0]  cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DataW-1:0]  term_coeff_i;
  logic        [ExpW-1:0]   term_exp_i;
  logic                     last_term_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DataW-1:0]  value_o;

  // Predictor state.
  data_t         eval_point = '0;
  data_t         partial_sum = '0;
  data_t         values_due[$];
  known_answer_t known_answers[$];
  int            mismatches = 0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_outputs = 1'b0;

  // Phases of the directed part. Point writes are taken only once the block
  // is idle, and some of them land in the middle of a polynomial.
  row_t directed_rows [DirectedRows] = '{
    '{ROW_TERM,  32'd5,   5'd0,  1'b1, 1'b1, 32'd5},     // zero to the zero is one
    '{ROW_TERM,  32'd7,   5'd31, 1'b1, 1'b1, 32'd0},
    '{ROW_TERM,  32'd0,   5'd31, 1'b1, 1'b1, 32'd0},     // zero coefficient
    '{ROW_TERM,  DataMax, 5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd1,   5'd0,  1'b1, 1'b1, DataMin},   // sum wraps
    '{ROW_TERM,  DataMin, 5'd0,  1'b1, 1'b1, DataMin},
    '{ROW_POINT, AllOnes, 5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd1,   5'd31, 1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd1,   5'd30, 1'b1, 1'b1, 32'd0},
    '{ROW_POINT, 32'd2,   5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd3,   5'd4,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  AllOnes, 5'd31, 1'b0, 1'b0, 32'd0},
    '{ROW_POINT, 32'd3,   5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd1,   5'd2,  1'b1, 1'b0, 32'd0},
    '{ROW_POINT, DataMax, 5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  DataMax, 5'd31, 1'b1, 1'b0, 32'd0},
    '{ROW_POINT, DataMin, 5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  AllOnes, 5'd1,  1'b1, 1'b1, DataMin},   // product wraps
    '{ROW_TERM,  32'd1,   5'd31, 1'b1, 1'b1, 32'd0},
    '{ROW_POINT, 32'd1,   5'd0,  1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  AllOnes, 5'd31, 1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'd1,   5'd0,  1'b1, 1'b1, 32'd0},
    '{ROW_POINT, 32'h5a5a_5a5a, 5'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_TERM,  32'ha5a5_a5a5, 5'd21, 1'b1, 1'b0, 32'd0}
  };

  sparse_polynomial_evaluator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .term_coeff_i (term_coeff_i),
    .term_exp_i   (term_exp_i),
    .last_term_i  (last_term_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Point raised to an exponent, wrapped to the data width.
  function automatic data_t raise_to(data_t base, exp_t e);
    data_t acc;
    int    b;
    acc = data_t'(1);
    for (b = ExpW - 1; b >= 0; b--) begin
      acc = acc * acc;
      if (e[b]) begin
        acc = acc * base;
      end
    end
    return acc;
  endfunction

  function automatic data_t pick_coeff();
    case ($urandom_range(5))
      0: return DataMax;
      1: return DataMin;
      2: return data_t'($urandom_range(16)) - data_t'(8);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic data_t pick_point();
    case ($urandom_range(7))
      0: return '0;
      1: return data_t'(1);
      2: return AllOnes;
      3: return data_t'(2);
      4: return DataMax;
      5: return DataMin;
      6: return data_t'($urandom_range(10)) - data_t'(5);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 20;
      default: return 50;
    endcase
  endfunction

  // Predicts each accepted request and checks each accepted result.
  always @(posedge clk_i) begin : scoreboard
    known_answer_t known;
    data_t         due;
    if (rst_ni) begin
      if (cfg_we_i) begin
        eval_point = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        known = known_answers.pop_front();
        partial_sum = partial_sum + data_t'(term_coeff_i) * raise_to(eval_point, term_exp_i);
        if (last_term_i) begin
          values_due.push_back(known.fixed ? known.answer : partial_sum);
          partial_sum = '0;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (values_due.size() == 0) begin
          $error("value: expected none, actual %0d", value_o);
          mismatches++;
        end else begin
          due = values_due.pop_front();
          if (value_o !== due) begin
            $error("value: expected %0d, actual %0d", $signed(due), value_o);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_outputs) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_outputs = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_term(input data_t coeff, input exp_t e, input logic last,
                           input logic fixed, input data_t answer);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    known_answers.push_back('{fixed, answer});
    in_valid_i <= 1'b1;
    term_coeff_i <= coeff;
    term_exp_i <= e;
    last_term_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every result has come back and no term is left in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (values_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_point(input data_t point);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= point;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int   sent;
    int   phase;
    int   phase_len;
    int   n;
    int   len;
    int   k;
    row_t row;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    term_coeff_i <= '0;
    term_exp_i <= '0;
    last_term_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 30;
    rx_stall_pct = 30;
    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_POINT) begin
        write_point(row.data);
      end else begin
        send_term(row.data, row.e, row.last, row.fixed, row.answer);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RandomTerms) begin
      write_point(pick_point());
      if (sent >= RandomTerms - QuietTail) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct = pick_pct();
        rx_stall_pct = pick_pct();
      end
      if (phase == 2) begin
        // Results back up behind a stalled receiver until the input stalls too.
        tx_idle_pct = 0;
        hold_outputs = 1'b1;
        for (n = 0; n < 40; n++) begin
          send_term(pick_coeff(), exp_t'($urandom_range(31)), 1'b1, 1'b0, '0);
        end
        sent += 40;
      end
      phase_len = $urandom_range(60, 200);
      n = 0;
      while (n < phase_len) begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          send_term(pick_coeff(), exp_t'($urandom_range(31)), k == len - 1, 1'b0, '0);
        end
        n += len;
      end
      // Sometimes leave a polynomial open so the next point lands inside it.
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(1, 2);
        for (k = 0; k < len; k++) begin
          send_term(pick_coeff(), exp_t'($urandom_range(31)), 1'b0, 1'b0, '0);
        end
        n += len;
      end
      sent += n;
      phase++;
    end
    send_term(pick_coeff(), exp_t'($urandom_range(31)), 1'b1, 1'b0, '0);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spe_pkg.sv
hw/rtl/spe_mul.sv
hw/rtl/sparse_polynomial_evaluator.sv
dv/testbench.sv
